FILE: src/e2cd_pkg.sv
// e2cd_pkg: shared types, codes, constant tables and divider settings for the
// epoch to calendar date converter. No dependencies.
`default_nettype none

package e2cd_pkg;

  // shared divider, radix 2^6 long division
  localparam int STEP_BITS = 6;
  localparam int ACC_W     = 42;
  localparam int DIVISOR_W = 17;
  localparam int REM_W     = 17;

  // years 1970 .. 2106 are reachable from a 32-bit seconds count
  localparam int YEAR_SPAN = 137;
  localparam int BASE_YEAR = 1970;

  typedef enum logic [2:0] {
    OP_MS,
    OP_DAY,
    OP_HR,
    OP_MIN,
    OP_WK,
    OP_YR
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MS,
    ST_DAY,
    ST_HR,
    ST_MIN,
    ST_WK,
    ST_YR,
    ST_YLOAD,
    ST_YFIX,
    ST_YDAY,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    in_load;
    logic    div_en;
    logic    div_load;
    div_op_t div_op;
    logic    yoff_load;
    logic    yoff_dec;
    logic    yday_load;
    logic    month_load;
    logic    out_load;
  } e2cd_cmd_t;

  typedef struct packed {
    logic ys_gt;
  } e2cd_status_t;

  typedef logic [8:0]  cum_tab_t [0:12];
  typedef logic [15:0] ys_tab_t  [0:YEAR_SPAN-1];
  typedef logic [YEAR_SPAN-1:0] leap_tab_t;

  localparam cum_tab_t CUM_NORMAL = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam cum_tab_t CUM_LEAP = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };

  // day index of 1 january for each year offset
  function automatic ys_tab_t build_year_start();
    ys_tab_t t;
    int      y;
    for (int k = 0; k < YEAR_SPAN; k++) begin
      y    = BASE_YEAR + k;
      t[k] = 16'((y - BASE_YEAR) * 365 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400
                 - ((BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100 + (BASE_YEAR - 1) / 400));
    end
    return t;
  endfunction

  function automatic leap_tab_t build_leap();
    leap_tab_t t;
    int        y;
    for (int k = 0; k < YEAR_SPAN; k++) begin
      y    = BASE_YEAR + k;
      t[k] = ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
    end
    return t;
  endfunction

  localparam ys_tab_t   YS_TAB   = build_year_start();
  localparam leap_tab_t LEAP_TAB = build_leap();

  function automatic logic [DIVISOR_W-1:0] div_divisor(input div_op_t op);
    logic [DIVISOR_W-1:0] d;
    case (op)
      OP_MS:   d = 17'd1000;
      OP_DAY:  d = 17'd86400;
      OP_HR:   d = 17'd3600;
      OP_MIN:  d = 17'd60;
      OP_WK:   d = 17'd7;
      OP_YR:   d = 17'd365;
      default: d = 17'd1;
    endcase
    return d;
  endfunction

  // number of radix steps covering each dividend
  function automatic logic [2:0] div_steps(input div_op_t op);
    logic [2:0] s;
    case (op)
      OP_MS:   s = 3'd7;
      OP_DAY:  s = 3'd6;
      OP_HR:   s = 3'd3;
      OP_MIN:  s = 3'd2;
      OP_WK:   s = 3'd3;
      OP_YR:   s = 3'd3;
      default: s = 3'd2;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/e2cd_div.sv
// e2cd_div: shared constant-divisor long division unit, six quotient bits a cycle.
// Advances only while en is high. Depends on e2cd_pkg.
`default_nettype none

module e2cd_div import e2cd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             load,
  input  wire div_op_t          op,
  input  wire logic [ACC_W-1:0] dividend,
  output logic      [ACC_W-1:0] quot,
  output logic      [REM_W-1:0] rem
);

  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [REM_W:0]       part;
  logic [ACC_W-1:0]     shf;
  logic [DIVISOR_W-1:0] dvs;

  always_comb begin
    dvs  = div_divisor(op);
    shf  = load ? dividend : acc_r;
    part = load ? '0 : {1'b0, rem_r};
    for (int i = 0; i < STEP_BITS; i++) begin
      part = {part[REM_W-1:0], shf[ACC_W-1]};
      shf  = {shf[ACC_W-2:0], 1'b0};
      if (part >= {1'b0, dvs}) begin
        part   = part - {1'b0, dvs};
        shf[0] = 1'b1;
      end
    end
    acc_nxt = shf;
    rem_nxt = part[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = acc_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: src/e2cd_dp.sv
// e2cd_dp: datapath of the converter: input and zone registers, divider, year and
// month lookup, result register. Depends on e2cd_pkg and e2cd_div.
`default_nettype none

module e2cd_dp import e2cd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire e2cd_cmd_t           cmd,
  output e2cd_status_t             status,
  input  wire logic [41:0]         in_epoch_ms,
  input  wire logic                cfg_wr_en,
  input  wire logic signed [16:0]  cfg_wr_data,
  output logic                     out_valid_res,
  output logic [11:0]              out_year,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month,
  output logic [8:0]               out_day_of_year,
  output logic [2:0]               out_weekday,
  output logic [4:0]               out_hour,
  output logic [5:0]               out_minute,
  output logic [5:0]               out_second,
  output logic [9:0]               out_millisecond
);

  logic signed [16:0] zone_r;
  logic [41:0]        epoch_r;
  logic               zero_r;
  logic [9:0]         ms_r;
  logic [15:0]        nday_r;
  logic [4:0]         hour_r;
  logic [5:0]         minute_r;
  logic [5:0]         second_r;
  logic [2:0]         weekday_r;
  logic [7:0]         yoff_r;
  logic [8:0]         yday_r;
  logic               leap_r;
  logic [3:0]         month_r;

  logic [ACC_W-1:0]   div_quot;
  logic [REM_W-1:0]   div_rem;
  logic [ACC_W-1:0]   dividend;
  logic [31:0]        secs_loc;
  logic [15:0]        nday_p3;
  logic [15:0]        ys_val;
  logic [15:0]        yday_diff;
  logic [8:0]         yday_calc;
  logic [3:0]         month_calc;
  logic [3:0]         month_idx;
  logic [8:0]         cum_prev;
  logic [4:0]         dom_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (cfg_wr_en) begin
      zone_r <= cfg_wr_data;
    end
  end

  // local seconds, 32-bit wrap
  assign secs_loc = div_quot[31:0] + {{15{zone_r[16]}}, zone_r};
  assign nday_p3  = nday_r + 16'd3;

  // dividend aligned to the top of the step window of each division
  always_comb begin
    case (cmd.div_op)
      OP_MS:   dividend = epoch_r;
      OP_DAY:  dividend = {4'b0, secs_loc, 6'b0};
      OP_HR:   dividend = {1'b0, div_rem, 24'b0};
      OP_MIN:  dividend = {div_rem[11:0], 30'b0};
      OP_WK:   dividend = {2'b0, nday_p3, 24'b0};
      OP_YR:   dividend = {2'b0, nday_r, 24'b0};
      default: dividend = epoch_r;
    endcase
  end

  e2cd_div u_div (
    .clk      (clk),
    .en       (cmd.div_en),
    .load     (cmd.div_load),
    .op       (cmd.div_op),
    .dividend (dividend),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign ys_val       = YS_TAB[yoff_r];
  assign status.ys_gt = (yoff_r != 8'd0) && (ys_val > nday_r);

  assign yday_diff = nday_r - ys_val;
  assign yday_calc = yday_diff[8:0] + 9'd1;

  always_comb begin
    month_calc = 4'd1;
    for (int m = 1; m < 12; m++) begin
      if ((leap_r ? CUM_LEAP[m] : CUM_NORMAL[m]) < yday_r) begin
        month_calc = month_calc + 4'd1;
      end
    end
  end

  assign month_idx = month_r - 4'd1;
  assign cum_prev  = leap_r ? CUM_LEAP[month_idx] : CUM_NORMAL[month_idx];
  assign dom_calc  = 5'(yday_r - cum_prev);

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      epoch_r <= in_epoch_ms;
      zero_r  <= (in_epoch_ms == 42'd0);
    end
    // each division launch picks up the result of the one before
    if (cmd.div_load) begin
      case (cmd.div_op)
        OP_DAY: ms_r   <= div_rem[9:0];
        OP_HR:  nday_r <= div_quot[15:0];
        OP_MIN: hour_r <= div_quot[4:0];
        OP_WK: begin
          minute_r <= div_quot[5:0];
          second_r <= div_rem[5:0];
        end
        OP_YR:  weekday_r <= div_rem[2:0] + 3'd1;
        default: ;
      endcase
    end
    if (cmd.yoff_load) begin
      yoff_r <= div_quot[7:0];
    end else if (cmd.yoff_dec) begin
      yoff_r <= yoff_r - 8'd1;
    end
    if (cmd.yday_load) begin
      yday_r <= yday_calc;
      leap_r <= LEAP_TAB[yoff_r];
    end
    if (cmd.month_load) begin
      month_r <= month_calc;
    end
    if (cmd.out_load) begin
      out_valid_res    <= !zero_r;
      out_year         <= zero_r ? 12'd0 : 12'(BASE_YEAR) + {4'b0, yoff_r};
      out_month        <= zero_r ? 4'd0 : month_r;
      out_day_of_month <= zero_r ? 5'd0 : dom_calc;
      out_day_of_year  <= zero_r ? 9'd0 : yday_r;
      out_weekday      <= zero_r ? 3'd0 : weekday_r;
      out_hour         <= zero_r ? 5'd0 : hour_r;
      out_minute       <= zero_r ? 6'd0 : minute_r;
      out_second       <= zero_r ? 6'd0 : second_r;
      out_millisecond  <= zero_r ? 10'd0 : ms_r;
    end
  end

endmodule

`default_nettype wire

FILE: src/e2cd_ctrl.sv
// e2cd_ctrl: sequencing state machine of the converter, drives datapath commands
// and both handshakes. Depends on e2cd_pkg.
`default_nettype none

module e2cd_ctrl import e2cd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire e2cd_status_t status,
  output e2cd_cmd_t         cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_div;
  logic       div_last;
  logic       out_free;
  div_op_t    op;

  always_comb begin
    case (state_r)
      ST_MS:   op = OP_MS;
      ST_DAY:  op = OP_DAY;
      ST_HR:   op = OP_HR;
      ST_MIN:  op = OP_MIN;
      ST_WK:   op = OP_WK;
      ST_YR:   op = OP_YR;
      default: op = OP_MS;
    endcase
  end

  assign is_div   = state_r inside {ST_MS, ST_DAY, ST_HR, ST_MIN, ST_WK, ST_YR};
  assign div_last = is_div && (cnt_r == 3'd1);
  assign out_free = !out_valid_r || out_ready;

  // zero on entry to a division state means launch
  always_comb begin
    if (!is_div) begin
      cnt_nxt = 3'd0;
    end else if (cnt_r == 3'd0) begin
      cnt_nxt = div_steps(op) - 3'd1;
    end else begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MS;
      ST_MS:    if (div_last) state_nxt = ST_DAY;
      ST_DAY:   if (div_last) state_nxt = ST_HR;
      ST_HR:    if (div_last) state_nxt = ST_MIN;
      ST_MIN:   if (div_last) state_nxt = ST_WK;
      ST_WK:    if (div_last) state_nxt = ST_YR;
      ST_YR:    if (div_last) state_nxt = ST_YLOAD;
      ST_YLOAD: state_nxt = ST_YFIX;
      ST_YFIX:  if (!status.ys_gt) state_nxt = ST_YDAY;
      ST_YDAY:  state_nxt = ST_MONTH;
      ST_MONTH: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_op   = op;
    cmd.div_en   = is_div;
    cmd.div_load = is_div && (cnt_r == 3'd0);
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      ST_YLOAD: cmd.yoff_load  = 1'b1;
      ST_YFIX:  cmd.yoff_dec   = status.ys_gt;
      ST_YDAY:  cmd.yday_load  = 1'b1;
      ST_MONTH: cmd.month_load = 1'b1;
      ST_DONE:  cmd.out_load   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: src/epoch_to_calendar_date_core.sv
// epoch_to_calendar_date_core: top level of the millisecond timestamp to calendar
// date converter. Depends on e2cd_pkg, e2cd_ctrl, e2cd_dp (and e2cd_div below it).
//
// usage
// - input channel in_valid / in_ready carries one 42-bit millisecond count per beat
// - result channel out_valid / out_ready carries one date beat per input beat;
//   a zero timestamp gives out_valid_res low and all other fields zero
// - cfg_wr_en with cfg_wr_data writes the signed zone offset in seconds; write it
//   only while no conversion is in flight
// - one item at a time: the shared six-bit-per-cycle divider runs six divisions
//   (ms, day, hour, minute, weekday, year), then year correction, day of year,
//   month search and result load follow
// - in_ready returns in the cycle after the result register is loaded
// - the result register holds a finished beat while the receiver stalls, and the
//   next input beat is taken meanwhile; only the final load waits for it
// - synchronous reset clears the controller, the result valid and the offset (0)
`default_nettype none

module epoch_to_calendar_date_core import e2cd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [41:0]        in_epoch_ms,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_valid_res,
  output logic [11:0]             out_year,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day_of_month,
  output logic [8:0]              out_day_of_year,
  output logic [2:0]              out_weekday,
  output logic [4:0]              out_hour,
  output logic [5:0]              out_minute,
  output logic [5:0]              out_second,
  output logic [9:0]              out_millisecond,
  // zone offset register
  input  wire logic               cfg_wr_en,
  input  wire logic signed [16:0] cfg_wr_data
);

  e2cd_cmd_t    cmd;
  e2cd_status_t status;

  // controller: sequencing, step counting, handshakes
  e2cd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: divider, calendar tables, result register
  e2cd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_epoch_ms      (in_epoch_ms),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid_res    (out_valid_res),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_day_of_year  (out_day_of_year),
    .out_weekday      (out_weekday),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_millisecond  (out_millisecond)
  );

`ifndef ASSERT_OFF
  // once a beat is taken the block is busy for the whole conversion
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted beat");

  // datapath commands of different phases never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.in_load, cmd.div_en, cmd.yoff_load, cmd.yoff_dec,
              cmd.yday_load, cmd.month_load, cmd.out_load}))
    else $error("overlapping datapath commands");

  // a result load always shows as a pending beat
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not offered");

  // a zero timestamp yields zero year, month, day of year and weekday
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_year == 12'd0 && out_month == 4'd0 &&
      out_day_of_year == 9'd0 && out_weekday == 3'd0)
    else $error("invalid result with non-zero fields");
`endif

endmodule

`default_nettype wire
